[design/itpc_pkg.sv]
`default_nettype none
package itpc_pkg;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam logic [2:0] PREC_ADD = 3'd1;
    localparam logic [2:0] PREC_MUL = 3'd2;
    localparam logic [2:0] PREC_POW = 3'd3;
    localparam logic [2:0] PREC_MOD = 3'd4;
    localparam logic [2:0] PREC_NONE = 3'd0;

    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        K_OPND = 2'd0,
        K_OPER = 2'd1,
        K_LPAR = 2'd2,
        K_RPAR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        t_kind      kind;
        logic [2:0] prec;
    } t_tok;

    typedef struct packed {
        t_tok tok;
        logic last;
    } t_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
        logic       err;
    } t_res;

endpackage
`default_nettype wire

[design/itpc_front.sv]
`default_nettype none
module itpc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_char,
    input  wire                 i_last,
    output logic                o_ready,
    output logic                o_q_valid,
    output itpc_pkg::t_item     o_q_item,
    input  wire                 i_q_ready
);

    logic            r_valid;
    itpc_pkg::t_item r_item;

    function automatic itpc_pkg::t_tok classify(input logic [7:0] c);
        itpc_pkg::t_tok t;
        t.ch   = c;
        t.kind = itpc_pkg::K_OPER;
        t.prec = itpc_pkg::PREC_NONE;
        unique case (c)
            itpc_pkg::CH_PLUS, itpc_pkg::CH_MINUS: t.prec = itpc_pkg::PREC_ADD;
            itpc_pkg::CH_STAR, itpc_pkg::CH_SLASH: t.prec = itpc_pkg::PREC_MUL;
            itpc_pkg::CH_CARET:  t.prec = itpc_pkg::PREC_POW;
            itpc_pkg::CH_PCT:    t.prec = itpc_pkg::PREC_MOD;
            itpc_pkg::CH_LPAREN: t.kind = itpc_pkg::K_LPAR;
            itpc_pkg::CH_RPAREN: t.kind = itpc_pkg::K_RPAR;
            default:             t.kind = itpc_pkg::K_OPND;
        endcase
        return t;
    endfunction

    assign o_ready   = !r_valid || i_q_ready;
    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.tok  <= classify(i_char);
            r_item.last <= i_last;
        end
    end

endmodule
`default_nettype wire

[design/itpc_queue.sv]
`default_nettype none
module itpc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire itpc_pkg::t_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    output itpc_pkg::t_item     o_item,
    input  wire                 i_ready
);

    localparam int QAW = $clog2(itpc_pkg::QDEPTH);

    itpc_pkg::t_item r_mem [itpc_pkg::QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QAW:0]    r_cnt;
    logic            push;
    logic            pop;

    assign o_ready = r_cnt != (QAW+1)'(itpc_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

[design/itpc_back.sv]
`default_nettype none
module itpc_back #(
    parameter int MAX_LEN = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  wire itpc_pkg::t_item i_q_item,
    output logic                o_q_ready,
    output logic                o_res_valid,
    output itpc_pkg::t_res      o_res,
    input  wire                 i_res_ready
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    typedef enum logic [7:0] {
        S_FILL  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_PROC  = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_DRAIN = 8'b0001_0000,
        S_EMIT  = 8'b0010_0000,
        S_OLOAD = 8'b0100_0000,
        S_STAT  = 8'b1000_0000
    } t_state;

    itpc_pkg::t_tok mem_expr  [MAX_LEN];
    itpc_pkg::t_tok mem_stack [MAX_LEN];
    logic [7:0]     mem_out   [MAX_LEN];

    t_state         r_state, n_state;
    t_state         r_ret, n_ret;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_fault, n_fault;
    logic [AW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_sp, n_sp;
    itpc_pkg::t_tok r_top, n_top;
    logic [CW-1:0]  r_n, n_n;
    logic [AW-1:0]  r_k, n_k;
    logic           r_stat_err, n_stat_err;
    logic           r_ovalid, n_ovalid;
    itpc_pkg::t_res r_ores, n_ores;
    itpc_pkg::t_tok r_xdata;
    itpc_pkg::t_tok r_sdata;
    logic [7:0]     r_odata;

    logic           expr_we;
    logic           stk_we;
    logic           out_we;
    logic [7:0]     out_wd;
    logic           top_ok;
    logic           slot_free;
    logic [AW-1:0]  stk_ra;

    assign o_q_ready   = r_state == S_FILL;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_ores;
    assign top_ok      = (r_sp != '0) && (r_top.kind != itpc_pkg::K_RPAR);
    assign slot_free   = !r_ovalid || i_res_ready;
    assign stk_ra      = AW'(r_sp - CW'(2));

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_cnt      = r_cnt;
        n_fault    = r_fault;
        n_idx      = r_idx;
        n_sp       = r_sp;
        n_top      = r_top;
        n_n        = r_n;
        n_k        = r_k;
        n_stat_err = r_stat_err;
        n_ovalid   = r_ovalid && !i_res_ready;
        n_ores     = r_ores;
        expr_we    = 1'b0;
        stk_we     = 1'b0;
        out_we     = 1'b0;
        out_wd     = r_top.ch;

        unique case (r_state)
            S_FILL: begin
                if (i_q_valid) begin
                    if (r_cnt < CW'(MAX_LEN)) begin
                        expr_we = 1'b1;
                        n_cnt   = r_cnt + CW'(1);
                    end else begin
                        n_fault = 1'b1;
                    end
                    if (i_q_item.last) begin
                        n_sp = '0;
                        n_n  = '0;
                        if (r_fault || r_cnt == CW'(MAX_LEN)) begin
                            n_stat_err = 1'b1;
                            n_state    = S_STAT;
                        end else begin
                            n_idx   = AW'(r_cnt);
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_PROC;
            end
            S_PROC: begin
                unique case (r_xdata.kind)
                    itpc_pkg::K_OPND: begin
                        out_we = 1'b1;
                        out_wd = r_xdata.ch;
                        n_n    = r_n + CW'(1);
                        n_ret  = S_RD;
                    end
                    itpc_pkg::K_RPAR: begin
                        stk_we = r_sp != '0;
                        n_top  = r_xdata;
                        n_sp   = r_sp + CW'(1);
                        n_ret  = S_RD;
                    end
                    itpc_pkg::K_LPAR: begin
                        if (top_ok) begin
                            out_we = 1'b1;
                            n_n    = r_n + CW'(1);
                            n_ret  = S_PROC;
                        end else begin
                            n_ret  = S_RD;
                        end
                    end
                    itpc_pkg::K_OPER: begin
                        if (top_ok && ((r_top.prec > r_xdata.prec) ||
                            (r_top.prec == r_xdata.prec &&
                             r_xdata.ch == itpc_pkg::CH_CARET))) begin
                            out_we = 1'b1;
                            n_n    = r_n + CW'(1);
                            n_ret  = S_PROC;
                        end else begin
                            stk_we = r_sp != '0;
                            n_top  = r_xdata;
                            n_sp   = r_sp + CW'(1);
                            n_ret  = S_RD;
                        end
                    end
                    default: begin
                        n_ret = S_RD;
                    end
                endcase
                if (r_xdata.kind == itpc_pkg::K_LPAR && r_sp == '0) begin
                    n_stat_err = 1'b1;
                    n_state    = S_STAT;
                end else if (out_we && r_xdata.kind != itpc_pkg::K_OPND) begin
                    n_sp    = r_sp - CW'(1);
                    n_state = S_LOAD;
                end else if (r_xdata.kind == itpc_pkg::K_LPAR) begin
                    n_sp    = r_sp - CW'(1);
                    n_state = S_LOAD;
                end else if (r_idx == '0) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = S_RD;
                end
            end
            S_LOAD: begin
                if (r_sp != '0) begin
                    n_top = r_sdata;
                end
                if (r_ret != S_RD) begin
                    n_state = r_ret;
                end else if (r_idx == '0) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = S_RD;
                end
            end
            S_DRAIN: begin
                if (r_sp == '0) begin
                    if (r_n == '0) begin
                        n_stat_err = 1'b0;
                        n_state    = S_STAT;
                    end else begin
                        n_k     = AW'(r_n - CW'(1));
                        n_state = S_EMIT;
                    end
                end else if (r_top.kind == itpc_pkg::K_RPAR) begin
                    n_stat_err = 1'b1;
                    n_state    = S_STAT;
                end else begin
                    out_we  = 1'b1;
                    n_n     = r_n + CW'(1);
                    n_sp    = r_sp - CW'(1);
                    n_ret   = S_DRAIN;
                    n_state = S_LOAD;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_OLOAD;
                end
            end
            S_OLOAD: begin
                n_ovalid     = 1'b1;
                n_ores.ch    = r_odata;
                n_ores.last  = r_k == '0;
                n_ores.empty = 1'b0;
                n_ores.err   = 1'b0;
                if (r_k == '0) begin
                    n_cnt   = '0;
                    n_fault = 1'b0;
                    n_sp    = '0;
                    n_n     = '0;
                    n_state = S_FILL;
                end else begin
                    n_k     = r_k - AW'(1);
                    n_state = S_EMIT;
                end
            end
            S_STAT: begin
                if (slot_free) begin
                    n_ovalid     = 1'b1;
                    n_ores.ch    = '0;
                    n_ores.last  = 1'b1;
                    n_ores.empty = !r_stat_err;
                    n_ores.err   = r_stat_err;
                    n_cnt        = '0;
                    n_fault      = 1'b0;
                    n_sp         = '0;
                    n_n          = '0;
                    n_state      = S_FILL;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_ret      <= S_RD;
            r_cnt      <= '0;
            r_fault    <= 1'b0;
            r_sp       <= '0;
            r_n        <= '0;
            r_stat_err <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_cnt      <= n_cnt;
            r_fault    <= n_fault;
            r_sp       <= n_sp;
            r_n        <= n_n;
            r_stat_err <= n_stat_err;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_top  <= n_top;
        r_k    <= n_k;
        r_ores <= n_ores;
    end

    // buffered expression, operator stack and collected output
    always_ff @(posedge i_clk) begin
        if (expr_we) begin
            mem_expr[AW'(r_cnt)] <= i_q_item.tok;
        end
        r_xdata <= mem_expr[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stack[AW'(r_sp - CW'(1))] <= r_top;
        end
        r_sdata <= mem_stack[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (out_we) begin
            mem_out[AW'(r_n)] <= out_wd;
        end
        r_odata <= mem_out[r_k];
    end

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= r_cnt)
        else $error("operator stack deeper than buffered expression");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= r_cnt)
        else $error("more output characters than buffered characters");

    a_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OLOAD |-> !r_ovalid)
        else $error("output register overwritten before transfer");

    a_fault_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> r_cnt == CW'(MAX_LEN))
        else $error("overflow flagged with buffer not full");
`endif

endmodule
`default_nettype wire

[design/infix_to_prefix_converter_unit.sv]
// Infix to prefix converter. Characters arrive one per transfer on the slave
// stream, the last one marked by tlast; each passes a classifying input stage
// and a four-entry queue, then is written to the expression buffer, so input
// flows at one transfer per cycle until the queue fills behind a conversion.
// After the marked character the back end scans the buffer right to left with
// an operator stack and then sends the prefix expression on the master stream,
// tlast on its final character. Each character costs a buffer read, then a
// decision; each operator pop and each matched parenthesis pair adds a stack
// memory read, and each result takes an output buffer read, then a load.
// Input stalls meanwhile. An unmatched parenthesis or more than MAX_LEN
// characters gives a single result with tuser error bit set, an empty
// expression a single result with the empty bit.
`default_nettype none
module infix_to_prefix_converter_unit #(
    parameter int MAX_LEN = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // char_in
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // char_out
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser    // out_empty, err_flag
);

    logic            f_valid;
    itpc_pkg::t_item f_item;
    logic            f_ready;
    logic            q_valid;
    itpc_pkg::t_item q_item;
    logic            q_ready;
    itpc_pkg::t_res  res;

    itpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_char    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_ready   (o_s_axis_tready),
        .o_q_valid (f_valid),
        .o_q_item  (f_item),
        .i_q_ready (f_ready)
    );

    itpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    itpc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_ready   (q_ready),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = res.ch;
    assign o_m_axis_tlast = res.last;
    assign o_m_axis_tuser = {res.err, res.empty};

endmodule
`default_nettype wire

[dv/infix_to_prefix_converter_unit_tb.sv]
module infix_to_prefix_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHARS   = 64;
    localparam int NOT_OPER    = -1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 400;
    localparam int RANDOM_CHARS = 240;

    typedef enum int {
        GEN_SHORT,
        GEN_LONG,
        GEN_BROKEN,
        GEN_NOISE,
        GEN_OVERLONG,
        GEN_FULL
    } t_gen_kind;

    class prefix_scoreboard;
        itpc_pkg::t_res prefix_q[$];
        logic [7:0]     expr_chars[$];
        bit             overflow;
        int             errors;
        int             chars_noted;
        int             exprs_noted;
        int             results_checked;
        int             status_results;

        function int prec_of(logic [7:0] c);
            case (c)
                itpc_pkg::CH_PLUS, itpc_pkg::CH_MINUS:    return int'(itpc_pkg::PREC_ADD);
                itpc_pkg::CH_STAR, itpc_pkg::CH_SLASH:    return int'(itpc_pkg::PREC_MUL);
                itpc_pkg::CH_CARET:                       return int'(itpc_pkg::PREC_POW);
                itpc_pkg::CH_PCT:                         return int'(itpc_pkg::PREC_MOD);
                itpc_pkg::CH_LPAREN, itpc_pkg::CH_RPAREN: return int'(itpc_pkg::PREC_NONE);
                default:                                  return NOT_OPER;
            endcase
        endfunction

        function void push_status(logic empty, logic err);
            itpc_pkg::t_res r;
            r.ch    = 8'h00;
            r.last  = 1'b1;
            r.empty = empty;
            r.err   = err;
            prefix_q.push_back(r);
            status_results++;
        endfunction

        // right-to-left scan with an operator stack, result built reversed
        function void to_prefix();
            logic [7:0]     stk[MAX_CHARS];
            logic [7:0]     rev[$];
            logic [7:0]     c;
            logic [7:0]     t;
            int             sc;
            int             p;
            int             q;
            bit             bad;
            itpc_pkg::t_res r;
            sc  = 0;
            bad = 1'b0;
            for (int i = expr_chars.size() - 1; i >= 0 && !bad; i--) begin
                c = expr_chars[i];
                if (prec_of(c) == NOT_OPER) begin
                    rev.push_back(c);
                end else if (c == itpc_pkg::CH_RPAREN) begin
                    stk[sc] = c;
                    sc++;
                end else if (c == itpc_pkg::CH_LPAREN) begin
                    while (sc > 0 && stk[sc-1] != itpc_pkg::CH_RPAREN) begin
                        sc--;
                        rev.push_back(stk[sc]);
                    end
                    if (sc == 0) bad = 1'b1;
                    else sc--;
                end else begin
                    p = prec_of(c);
                    while (sc > 0) begin
                        t = stk[sc-1];
                        q = prec_of(t);
                        if (t == itpc_pkg::CH_RPAREN) break;
                        if (q > p || (q == p && c == itpc_pkg::CH_CARET)) begin
                            sc--;
                            rev.push_back(t);
                        end else begin
                            break;
                        end
                    end
                    stk[sc] = c;
                    sc++;
                end
            end
            while (!bad && sc > 0) begin
                sc--;
                if (stk[sc] == itpc_pkg::CH_RPAREN) bad = 1'b1;
                else rev.push_back(stk[sc]);
            end
            if (bad) begin
                push_status(1'b0, 1'b1);
            end else if (rev.size() == 0) begin
                push_status(1'b1, 1'b0);
            end else begin
                for (int k = rev.size() - 1; k >= 0; k--) begin
                    r.ch    = rev[k];
                    r.last  = (k == 0);
                    r.empty = 1'b0;
                    r.err   = 1'b0;
                    prefix_q.push_back(r);
                end
            end
        endfunction

        function void note_char(logic [7:0] c, logic last);
            chars_noted++;
            if (expr_chars.size() < MAX_CHARS) expr_chars.push_back(c);
            else overflow = 1'b1;
            if (last) begin
                exprs_noted++;
                if (overflow) push_status(1'b0, 1'b1);
                else to_prefix();
                expr_chars.delete();
                overflow = 1'b0;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [7:0] ch, logic last, logic [1:0] user);
            itpc_pkg::t_res want;
            if (prefix_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual ch %h last %b user %b",
                         $time, ch, last, user);
                return;
            end
            want = prefix_q.pop_front();
            results_checked++;
            compare_field("char_out", want.ch, ch);
            compare_field("is_last_out", {7'd0, want.last}, {7'd0, last});
            compare_field("out_empty", {7'd0, want.empty}, {7'd0, user[0]});
            compare_field("err_flag", {7'd0, want.err}, {7'd0, user[1]});
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // char_in
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // char_out
    logic       m_tlast;
    logic [1:0] m_tuser;    // out_empty, err_flag

    prefix_scoreboard sb = new();
    logic [7:0]       expr_q[$];
    bit               tx_burst;
    int               cycles;

    infix_to_prefix_converter_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] rand_operand();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (sb.prec_of(c) != NOT_OPER);
        return c;
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 5))
            0:       return itpc_pkg::CH_PLUS;
            1:       return itpc_pkg::CH_MINUS;
            2:       return itpc_pkg::CH_STAR;
            3:       return itpc_pkg::CH_SLASH;
            4:       return itpc_pkg::CH_CARET;
            default: return itpc_pkg::CH_PCT;
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return itpc_pkg::CH_LPAREN;
            1:       return itpc_pkg::CH_RPAREN;
            default: return rand_operator();
        endcase
    endfunction

    task automatic build_expr(input t_gen_kind kind);
        int  nopd;
        int  open;
        int  len;
        int  pos;
        bit  first;
        expr_q.delete();
        case (kind)
            GEN_SHORT, GEN_LONG, GEN_BROKEN: begin
                nopd  = (kind == GEN_LONG) ? $urandom_range(10, 16) : $urandom_range(1, 6);
                open  = 0;
                first = 1'b1;
                repeat (nopd) begin
                    if (!first) expr_q.push_back(rand_operator());
                    first = 1'b0;
                    while ($urandom_range(0, 3) == 0 && open < 4) begin
                        expr_q.push_back(itpc_pkg::CH_LPAREN);
                        open++;
                    end
                    expr_q.push_back(rand_operand());
                    while (open > 0 && $urandom_range(0, 2) == 0) begin
                        expr_q.push_back(itpc_pkg::CH_RPAREN);
                        open--;
                    end
                end
                while (open > 0) begin
                    expr_q.push_back(itpc_pkg::CH_RPAREN);
                    open--;
                end
                if (kind == GEN_BROKEN) begin
                    pos = $urandom_range(0, expr_q.size());
                    expr_q.insert(pos, ($urandom_range(0, 1) == 0) ?
                                  itpc_pkg::CH_LPAREN : itpc_pkg::CH_RPAREN);
                end
            end
            GEN_NOISE: begin
                len = $urandom_range(1, 10);
                repeat (len) expr_q.push_back(noise_char());
            end
            GEN_OVERLONG: begin
                len = MAX_CHARS + $urandom_range(1, 6);
                repeat (len) expr_q.push_back(noise_char());
            end
            default: begin
                repeat (MAX_CHARS) expr_q.push_back(rand_operand());
            end
        endcase
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_char(c, last);
        @(negedge i_clk);
    endtask

    task automatic send_expr();
        tx_burst = ($urandom_range(0, 3) == 0);
        foreach (expr_q[i]) send_char(expr_q[i], i == expr_q.size() - 1);
    endtask

    task automatic send_string(input string s);
        expr_q.delete();
        for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
        send_expr();
    endtask

    initial begin : result_sink
        int gap;
        int burst_left;
        bit burst;
        m_tready   = 1'b0;
        burst_left = 0;
        burst      = 1'b0;
        @(negedge i_clk);
        forever begin
            if (burst_left == 0) begin
                burst      = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(8, 40);
            end
            burst_left--;
            gap = burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tlast, m_tuser);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int        random_chars;
        int        n_expr;
        int        r;
        t_gen_kind kind;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        tx_burst     = 1'b0;
        random_chars = 0;
        n_expr       = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single operand, empty parens, unmatched parens on both sides
        send_string("a");
        send_string("()");
        send_string("(a");
        send_string("a)");
        // right-associative power, then the other operators at mixed precedence
        send_string("a^b^c");
        send_string("a-b+c*d/e%f");
        // extreme operand codes
        expr_q.delete();
        expr_q.push_back(8'h00);
        expr_q.push_back(itpc_pkg::CH_STAR);
        expr_q.push_back(8'hFF);
        send_expr();

        while (random_chars < RANDOM_CHARS) begin
            r = $urandom_range(0, 99);
            if (n_expr == 2) kind = GEN_OVERLONG;
            else if (n_expr == 5) kind = GEN_FULL;
            else if (r < 65) kind = GEN_SHORT;
            else if (r < 75) kind = GEN_LONG;
            else if (r < 88) kind = GEN_BROKEN;
            else kind = GEN_NOISE;
            build_expr(kind);
            random_chars += expr_q.size();
            n_expr++;
            send_expr();
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (sb.prefix_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d expressions, %0d characters sent, %0d prefix results checked",
                 sb.exprs_noted, sb.chars_noted, sb.results_checked);
        $display("status results (error or empty) predicted: %0d, mismatches: %0d",
                 sb.status_results, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[infix_to_prefix_converter_unit.f]
design/itpc_pkg.sv
design/itpc_front.sv
design/itpc_queue.sv
design/itpc_back.sv
design/infix_to_prefix_converter_unit.sv
dv/infix_to_prefix_converter_unit_tb.sv
